[hdl/rau_pkg.sv]
// Package for the rational arithmetic unit: operation codes, sequencer
// states, product slot codes and the default word width.
// No dependencies.
package rau_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int REQ_TYPE_BITS = 3;

	typedef enum logic [REQ_TYPE_BITS-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_EQ  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHECK,
		ST_GCD,
		ST_DIV_NUM,
		ST_DIV_DEN,
		ST_FINISH
	} state_t;

	// Which of the up to three cross products the multiplier is working on
	typedef enum logic [1:0] {
		PROD_FIRST,
		PROD_SECOND,
		PROD_DEN
	} prod_t;

endpackage

[hdl/rau_if.sv]
// Valid/ready channel interfaces for the rational arithmetic unit:
// request (operation and two fractions) and response (reduced fraction, flags).
// Depends on rau_pkg.
interface rau_req_if #(
	parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
);
	logic                               valid;
	logic                               ready;
	logic [rau_pkg::REQ_TYPE_BITS-1:0]  req_type;
	logic [WORD_BITS-1:0]               a_num;
	logic [WORD_BITS-1:0]               a_den;
	logic [WORD_BITS-1:0]               b_num;
	logic [WORD_BITS-1:0]               b_den;

	modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if #(
	parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] res_num;
	logic [WORD_BITS-1:0] res_den;
	logic                 is_equal;
	logic                 zero_den_error;

	modport source (output valid, res_num, res_den, is_equal, zero_den_error, input ready);
	modport sink (input valid, res_num, res_den, is_equal, zero_den_error, output ready);
endinterface

[hdl/rational_arith_unit_core.sv]
// Rational arithmetic unit top level: add, subtract, multiply, divide and
// compare unsigned fractions, result reduced by a binary gcd.
// Depends on rau_pkg and rau_if (rau_req_if, rau_rsp_if).
//
// Usage
//  req  : one beat carries req_type and the fractions a_num/a_den, b_num/b_den.
//         A scalar operand is sent with denominator 1.
//  rsp  : one beat per request with res_num/res_den (reduced), is_equal
//         (equality test only) and zero_den_error (result forced to 0/1).
//  Products and sums wrap modulo 2^WORD_BITS.
// Sequencing
//  One request at a time; req.ready is high only while the sequencer idles.
//  Equality test and unused codes: straight from accept to ST_FINISH, then
//  the output register. Arithmetic: shift-add multiplies (one multiplier
//  bit per cycle, ending early when the remaining multiplier bits are zero),
//  a check state, binary gcd (one shift, swap or subtract per cycle), then two
//  restoring divisions, numerator first. All of it runs through a single
//  shared WORD_BITS+1 bit add/subtract unit.
// Reset and stalls
//  arst_n clears the sequencer and the response valid. A finished result sits
//  in the output register while rsp.ready is low; a new request is taken
//  meanwhile, and its result waits in ST_FINISH until the register frees up.
module rational_arith_unit_core #(
	parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rau_req_if.sink     req,
	rau_rsp_if.source   rsp
);
	import rau_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int KW = $clog2(WORD_BITS);   // common power-of-two count, < W
	localparam int CW = $clog2(WORD_BITS);   // division bit counter
	localparam logic [CW-1:0] CNT_LAST = CW'(WORD_BITS - 1);

	state_t state_q, state_d;

	// captured request
	logic [REQ_TYPE_BITS-1:0] op_q;
	logic [W-1:0] an_q, ad_q, bn_q, bd_q;

	// working registers
	logic [W-1:0]  num_q, den_q;   // running result fraction
	logic [W-1:0]  wa_q, wb_q;     // mult: multiplicand/multiplier; gcd: u/v; div: dividend
	logic [W-1:0]  g_q, rem_q;
	logic [KW-1:0] k_q;
	logic [CW-1:0] cnt_q;
	prod_t         idx_q;
	logic          eq_q, err_q;

	// output register
	logic          ovalid_q;
	logic [W-1:0]  res_num_q, res_den_q;
	logic          res_eq_q, res_err_q;

	// shared add/subtract unit
	logic         au_sub;
	logic [W:0]   au_a, au_b;
	logic [W+1:0] au_sum;
	logic         au_carry;
	logic [W:0]   au_res;

	// product operand selection
	logic [REQ_TYPE_BITS-1:0] src_op;
	logic [W-1:0] src_an, src_ad, src_bn, src_bd;
	prod_t        nidx;
	logic [W-1:0] opr_x, opr_y;

	logic req_fire, in_arith, src_arith;
	logic mul_next, mul_done;
	logic u_even, v_even, gcd_done;
	logic div_last, out_free;
	logic [W-1:0] quot_next;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;

	assign in_arith = (req.req_type == OP_ADD) || (req.req_type == OP_SUB) ||
		(req.req_type == OP_MUL) || (req.req_type == OP_DIV);

	// ---------------------------------------------------------------- shared unit
	always_comb begin
		au_sub = 1'b0;
		au_a   = '0;
		au_b   = '0;
		case (state_q)
			ST_MUL: begin
				au_a   = {1'b0, (idx_q == PROD_DEN) ? den_q : num_q};
				au_b   = {1'b0, wa_q};
				au_sub = (idx_q == PROD_SECOND) && (op_q == OP_SUB);
			end
			ST_GCD: begin
				au_a   = {1'b0, wa_q};
				au_b   = {1'b0, wb_q};
				au_sub = 1'b1;
			end
			ST_DIV_NUM, ST_DIV_DEN: begin
				au_a   = {rem_q, wa_q[W-1]};
				au_b   = {1'b0, g_q};
				au_sub = 1'b1;
			end
			default: begin
				au_sub = 1'b0;
			end
		endcase
	end

	assign au_sum   = {1'b0, au_a} + {1'b0, au_sub ? ~au_b : au_b} + (W+2)'(au_sub);
	assign au_carry = au_sum[W+1];   // on subtract: no borrow
	assign au_res   = au_sum[W:0];

	// ---------------------------------------------------------------- operand select
	assign src_arith = (src_op == OP_ADD) || (src_op == OP_SUB);

	always_comb begin
		if (state_q == ST_IDLE) begin
			src_op = req.req_type;
			src_an = req.a_num;
			src_ad = req.a_den;
			src_bn = req.b_num;
			src_bd = req.b_den;
			nidx   = PROD_FIRST;
		end else begin
			src_op = op_q;
			src_an = an_q;
			src_ad = ad_q;
			src_bn = bn_q;
			src_bd = bd_q;
			// the second cross product exists only for add and subtract
			nidx   = (idx_q == PROD_FIRST && src_arith) ? PROD_SECOND : PROD_DEN;
		end
		case (nidx)
			PROD_FIRST: begin
				opr_x = src_an;
				opr_y = (src_op == OP_MUL) ? src_bn : src_bd;
			end
			PROD_SECOND: begin
				opr_x = src_bn;
				opr_y = src_ad;
			end
			PROD_DEN: begin
				opr_x = src_ad;
				opr_y = (src_op == OP_DIV) ? src_bn : src_bd;
			end
			default: begin
				opr_x = '0;
				opr_y = '0;
			end
		endcase
	end

	// ---------------------------------------------------------------- sequencer
	assign mul_next  = (wb_q == '0);
	assign mul_done  = mul_next && (idx_q == PROD_DEN);
	assign u_even    = !wa_q[0];
	assign v_even    = !wb_q[0];
	assign gcd_done  = !u_even && !v_even && au_carry && (au_res[W-1:0] == '0);
	assign div_last  = (cnt_q == '0);
	assign out_free  = !ovalid_q || rsp.ready;
	assign quot_next = {wa_q[W-2:0], au_carry};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) state_d = in_arith ? ST_MUL : ST_FINISH;
			end
			ST_MUL: begin
				if (mul_done) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = (num_q == '0 || den_q == '0) ? ST_FINISH : ST_GCD;
			end
			ST_GCD: begin
				if (gcd_done) state_d = ST_DIV_NUM;
			end
			ST_DIV_NUM: begin
				if (div_last) state_d = ST_DIV_DEN;
			end
			ST_DIV_DEN: begin
				if (div_last) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					op_q  <= req.req_type;
					an_q  <= req.a_num;
					ad_q  <= req.a_den;
					bn_q  <= req.b_num;
					bd_q  <= req.b_den;
					wa_q  <= opr_x;
					wb_q  <= opr_y;
					idx_q <= PROD_FIRST;
					num_q <= '0;
					err_q <= 1'b0;
					if (in_arith) begin
						den_q <= '0;
						eq_q  <= 1'b0;
					end else begin
						den_q <= W'(1);
						eq_q  <= (req.req_type == OP_EQ) && (req.a_num == req.b_num) &&
							(req.a_den == req.b_den);
					end
				end
			end
			ST_MUL: begin
				if (mul_next) begin
					wa_q  <= opr_x;
					wb_q  <= opr_y;
					idx_q <= nidx;
				end else begin
					if (wb_q[0]) begin
						if (idx_q == PROD_DEN) den_q <= au_res[W-1:0];
						else                   num_q <= au_res[W-1:0];
					end
					wa_q <= {wa_q[W-2:0], 1'b0};
					wb_q <= {1'b0, wb_q[W-1:1]};
				end
			end
			ST_CHECK: begin
				if (num_q == '0) begin
					den_q <= W'(1);
				end else if (den_q == '0) begin
					err_q <= 1'b1;
					num_q <= '0;
					den_q <= W'(1);
				end else begin
					wa_q <= num_q;
					wb_q <= den_q;
					k_q  <= '0;
				end
			end
			ST_GCD: begin
				// binary gcd: strip twos, then subtract smaller odd from larger
				if (u_even && v_even) begin
					wa_q <= {1'b0, wa_q[W-1:1]};
					wb_q <= {1'b0, wb_q[W-1:1]};
					k_q  <= k_q + KW'(1);
				end else if (u_even) begin
					wa_q <= {1'b0, wa_q[W-1:1]};
				end else if (v_even) begin
					wb_q <= {1'b0, wb_q[W-1:1]};
				end else if (!au_carry) begin
					wa_q <= wb_q;
					wb_q <= wa_q;
				end else if (gcd_done) begin
					g_q   <= wa_q << k_q;
					wa_q  <= num_q;
					rem_q <= '0;
					cnt_q <= CNT_LAST;
				end else begin
					wa_q <= au_res[W-1:0];
				end
			end
			ST_DIV_NUM, ST_DIV_DEN: begin
				// restoring division by g, one quotient bit per cycle
				rem_q <= au_carry ? au_res[W-1:0] : au_a[W-1:0];
				wa_q  <= quot_next;
				cnt_q <= cnt_q - CW'(1);
				if (div_last) begin
					if (state_q == ST_DIV_NUM) begin
						num_q <= quot_next;
						wa_q  <= den_q;
						rem_q <= '0;
						cnt_q <= CNT_LAST;
					end else begin
						den_q <= quot_next;
					end
				end
			end
			default: begin
				num_q <= num_q;
			end
		endcase
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			res_num_q <= num_q;
			res_den_q <= den_q;
			res_eq_q  <= eq_q;
			res_err_q <= err_q;
		end
	end

	assign rsp.valid          = ovalid_q;
	assign rsp.res_num        = res_num_q;
	assign rsp.res_den        = res_den_q;
	assign rsp.is_equal       = res_eq_q;
	assign rsp.zero_den_error = res_err_q;

endmodule

[hdl/rau_checks.sv]
// Port-level checks for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg and rational_arith_unit_core.
module rau_checks #(
	parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [WORD_BITS-1:0] res_num,
	input logic [WORD_BITS-1:0] res_den,
	input logic                 is_equal,
	input logic                 zero_den_error
);
	import rau_pkg::*;

	// a response beat holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp.valid dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(res_num) && $stable(res_den) &&
			$stable(is_equal) && $stable(zero_den_error))
		else $error("rsp payload changed while stalled");

	// one request in flight: no accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// a zero denominator error always reports 0/1
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && zero_den_error |-> res_num == '0 && res_den == WORD_BITS'(1))
		else $error("error result is not 0/1");

	a_den_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> res_den != '0 && !(is_equal && zero_den_error))
		else $error("zero result denominator or conflicting flags");

endmodule

bind rational_arith_unit_core rau_checks #(.WORD_BITS(WORD_BITS)) u_rau_checks (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.res_num        (rsp.res_num),
	.res_den        (rsp.res_den),
	.is_equal       (rsp.is_equal),
	.zero_den_error (rsp.zero_den_error)
);

[tb/tb_rational_arith_unit_core.sv]
// Self-checking testbench for rational_arith_unit_core: fraction add, subtract,
// multiply, divide and equality test, checked beat by beat against a local predictor.
// Depends on rau_pkg, rau_if (rau_req_if, rau_rsp_if) and rational_arith_unit_core.
module tb_rational_arith_unit_core;
	import rau_pkg::*;

	localparam int W = WORD_BITS_DEF;

	// Codes 5..7 have no operation behind them; the block must answer 0/1.
	localparam logic [REQ_TYPE_BITS-1:0] CODE_SPARE5 = 3'd5;
	localparam logic [REQ_TYPE_BITS-1:0] CODE_SPARE6 = 3'd6;
	localparam logic [REQ_TYPE_BITS-1:0] CODE_SPARE7 = 3'd7;

	localparam logic [W-1:0] WMAX = '1;
	localparam logic [W-1:0] WMSB = {1'b1, {(W-1){1'b0}}};

	// Directed rows either carry a hand-written result or defer to the predictor.
	localparam bit BY_MODEL = 1'b0;
	localparam bit BY_HAND  = 1'b1;

	localparam int N_DIRECTED   = 23;
	localparam int N_PHASES     = 4;
	localparam int PER_PHASE    = 270;
	// Drain wait: worst-case request time plus margin.
	localparam int DRAIN_CYCLES = 8 * W + 64;
	// Runaway guard limit for the whole run of about 1100 beats.
	localparam int CYCLE_LIMIT  = 2_000_000;

	typedef struct packed {
		logic [REQ_TYPE_BITS-1:0] code;
		logic [W-1:0]             an;
		logic [W-1:0]             ad;
		logic [W-1:0]             bn;
		logic [W-1:0]             bd;
	} frac_req_t;

	typedef struct packed {
		logic [W-1:0] num;
		logic [W-1:0] den;
		logic         eq;
		logic         err;
	} frac_result_t;

	typedef struct packed {
		logic [REQ_TYPE_BITS-1:0] code;
		logic [W-1:0]             an;
		logic [W-1:0]             ad;
		logic [W-1:0]             bn;
		logic [W-1:0]             bd;
		bit                       by_hand;
		logic [W-1:0]             num;
		logic [W-1:0]             den;
		logic                     eq;
		logic                     err;
	} directed_row_t;

	// Directed stimulus: extremes, each operation, every special case.
	directed_row_t directed_rows [N_DIRECTED] = '{
		// plain arithmetic, checked by the predictor
		'{OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3, BY_MODEL, 32'd0, 32'd0, 1'b0, 1'b0},
		// 2 - 3 wraps the numerator
		'{OP_SUB, 32'd1, 32'd3, 32'd1, 32'd2, BY_MODEL, 32'd0, 32'd0, 1'b0, 1'b0},
		'{OP_MUL, 32'd2, 32'd3, 32'd3, 32'd4, BY_MODEL, 32'd0, 32'd0, 1'b0, 1'b0},
		// division by a scalar multiplies the denominator
		'{OP_DIV, 32'd6, 32'd1, 32'd4, 32'd1, BY_MODEL, 32'd0, 32'd0, 1'b0, 1'b0},
		// unreduced operands, result still reduced
		'{OP_ADD, 32'd4, 32'd8, 32'd2, 32'd4, BY_MODEL, 32'd0, 32'd0, 1'b0, 1'b0},
		'{OP_ADD, WMAX, WMAX, WMAX, WMAX, BY_MODEL, 32'd0, 32'd0, 1'b0, 1'b0},
		'{OP_MUL, WMAX, 32'd1, WMAX, 32'd1, BY_MODEL, 32'd0, 32'd0, 1'b0, 1'b0},
		'{OP_SUB, WMAX, 32'd1, 32'd0, 32'd1, BY_MODEL, 32'd0, 32'd0, 1'b0, 1'b0},
		// msb * msb wraps to a zero numerator
		'{OP_DIV, WMSB, 32'd3, 32'd5, WMSB, BY_HAND, 32'd0, 32'd1, 1'b0, 1'b0},
		// zero numerator
		'{OP_MUL, 32'd0, 32'd5, 32'd3, 32'd7, BY_HAND, 32'd0, 32'd1, 1'b0, 1'b0},
		// zero numerator wins over zero denominator
		'{OP_MUL, 32'd0, 32'd0, 32'd0, 32'd0, BY_HAND, 32'd0, 32'd1, 1'b0, 1'b0},
		'{OP_ADD, 32'd0, 32'd0, 32'd0, 32'd0, BY_HAND, 32'd0, 32'd1, 1'b0, 1'b0},
		'{OP_SUB, 32'd5, 32'd7, 32'd5, 32'd7, BY_HAND, 32'd0, 32'd1, 1'b0, 1'b0},
		// zero denominator: divide by zero fraction, and a wrapped product
		'{OP_DIV, 32'd3, 32'd4, 32'd0, 32'd5, BY_HAND, 32'd0, 32'd1, 1'b0, 1'b1},
		'{OP_MUL, 32'd1, 32'h10000, 32'd1, 32'h10000, BY_HAND, 32'd0, 32'd1, 1'b0, 1'b1},
		// equality test
		'{OP_EQ, 32'd7, 32'd9, 32'd7, 32'd9, BY_HAND, 32'd0, 32'd1, 1'b1, 1'b0},
		'{OP_EQ, 32'd7, 32'd9, 32'd8, 32'd9, BY_HAND, 32'd0, 32'd1, 1'b0, 1'b0},
		'{OP_EQ, 32'd7, 32'd9, 32'd7, 32'd10, BY_HAND, 32'd0, 32'd1, 1'b0, 1'b0},
		'{OP_EQ, WMAX, WMAX, WMAX, WMAX, BY_HAND, 32'd0, 32'd1, 1'b1, 1'b0},
		'{OP_EQ, 32'd0, 32'd0, 32'd0, 32'd0, BY_HAND, 32'd0, 32'd1, 1'b1, 1'b0},
		// unused codes
		'{CODE_SPARE5, WMAX, WMAX, WMAX, WMAX, BY_HAND, 32'd0, 32'd1, 1'b0, 1'b0},
		'{CODE_SPARE6, 32'd3, 32'd0, 32'd4, 32'd0, BY_HAND, 32'd0, 32'd1, 1'b0, 1'b0},
		'{CODE_SPARE7, 32'd7, 32'd9, 32'd7, 32'd9, BY_HAND, 32'd0, 32'd1, 1'b0, 1'b0}
	};

	// Idle percentages per phase: none, sender only, receiver only, both.
	int send_idle_pct [N_PHASES] = '{0, 73, 0, 31};
	int recv_stall_pct [N_PHASES] = '{0, 0, 73, 31};

	logic clk;
	logic arst_n;
	int   stall_pct;
	int   cycle_count = 0;
	int   mismatch_count = 0;
	int   result_count = 0;

	frac_result_t pending_results [$];

	rau_req_if #(.WORD_BITS(W)) req_ch ();
	rau_rsp_if #(.WORD_BITS(W)) rsp_ch ();

	rational_arith_unit_core #(
		.WORD_BITS(W)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Runaway guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [W-1:0] euclid_gcd(logic [W-1:0] x, logic [W-1:0] y);
		logic [W-1:0] r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// Reduced fraction the block should return for one request.
	function automatic frac_result_t predict_result(frac_req_t r);
		frac_result_t o;
		logic [W-1:0] num;
		logic [W-1:0] den;
		logic [W-1:0] g;
		bit           arith;
		num = '0;
		den = W'(1);
		arith = 1'b1;
		o = '{num: '0, den: W'(1), eq: 1'b0, err: 1'b0};
		// all products and sums truncate to W bits, i.e. wrap mod 2^W
		case (r.code)
			OP_ADD: begin
				num = r.an * r.bd + r.bn * r.ad;
				den = r.ad * r.bd;
			end
			OP_SUB: begin
				num = r.an * r.bd - r.bn * r.ad;
				den = r.ad * r.bd;
			end
			OP_MUL: begin
				num = r.an * r.bn;
				den = r.ad * r.bd;
			end
			OP_DIV: begin
				num = r.an * r.bd;
				den = r.ad * r.bn;
			end
			OP_EQ: begin
				o.eq = (r.an == r.bn) && (r.ad == r.bd);
				arith = 1'b0;
			end
			default: begin
				arith = 1'b0;
			end
		endcase
		if (arith) begin
			if (num == 0) begin
				// 0/1, even over a zero denominator
			end else if (den == 0) begin
				o.err = 1'b1;
			end else begin
				g = euclid_gcd(num, den);
				o.num = num / g;
				o.den = den / g;
			end
		end
		return o;
	endfunction

	// Operand values biased toward small numbers so gcds are interesting,
	// with extremes, powers of two and full-width noise mixed in.
	function automatic logic [W-1:0] draw_operand();
		case ($urandom_range(9))
			0, 1, 2: return $urandom_range(1, 20);
			3:       return $urandom_range(0, 1000);
			4:       return 1;
			5:       return WMSB >> $urandom_range(W - 1);
			6:       return WMAX - $urandom_range(3);
			7:       return ($urandom_range(3) == 0) ? '0 : $urandom_range(65535);
			default: return $urandom();
		endcase
	endfunction

	function automatic frac_req_t draw_request();
		frac_req_t r;
		logic [W-1:0] g;
		int pick;
		pick = $urandom_range(99);
		if (pick < 80)
			r.code = REQ_TYPE_BITS'($urandom_range(OP_ADD, OP_DIV));
		else if (pick < 92)
			r.code = OP_EQ;
		else
			r.code = REQ_TYPE_BITS'($urandom_range(CODE_SPARE5, CODE_SPARE7));
		r.an = draw_operand();
		r.ad = draw_operand();
		r.bn = draw_operand();
		r.bd = ($urandom_range(4) == 0) ? W'(1) : draw_operand();
		// most operands arrive reduced
		if ($urandom_range(3) != 0 && r.an != 0 && r.ad != 0) begin
			g = euclid_gcd(r.an, r.ad);
			r.an = r.an / g;
			r.ad = r.ad / g;
		end
		if ($urandom_range(3) != 0 && r.bn != 0 && r.bd != 0) begin
			g = euclid_gcd(r.bn, r.bd);
			r.bn = r.bn / g;
			r.bd = r.bd / g;
		end
		// make equality hits common
		if (r.code == OP_EQ && $urandom_range(1)) begin
			r.bn = r.an;
			r.bd = r.ad;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
		$display("mismatch at result %0d: %s got %h want %h", result_count, what, got, want);
		mismatch_count++;
	endtask

	// Drive one request beat, holding valid until accepted. Gaps, if any,
	// come before the beat so valid never drops and rises in one step.
	task automatic send_request(frac_req_t r, frac_result_t want, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= r.code;
		req_ch.a_num    <= r.an;
		req_ch.a_den    <= r.ad;
		req_ch.b_num    <= r.bn;
		req_ch.b_den    <= r.bd;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		pending_results.push_back(want);
	endtask

	task automatic check_result();
		frac_result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("beat with nothing outstanding", rsp_ch.res_num, '0);
		end else begin
			want = pending_results.pop_front();
			if (rsp_ch.res_num !== want.num)
				report_mismatch("res_num", rsp_ch.res_num, want.num);
			if (rsp_ch.res_den !== want.den)
				report_mismatch("res_den", rsp_ch.res_den, want.den);
			if (rsp_ch.is_equal !== want.eq)
				report_mismatch("is_equal", W'(rsp_ch.is_equal), W'(want.eq));
			if (rsp_ch.zero_den_error !== want.err)
				report_mismatch("zero_den_error", W'(rsp_ch.zero_den_error),
					W'(want.err));
		end
		result_count++;
	endtask

	// Response side: random backpressure per phase, checked on each beat.
	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				check_result();
		end
	end

	// Main sequence: reset, directed rows, four random phases, drain, verdict.
	initial begin
		frac_req_t    rq;
		frac_result_t want;
		stall_pct      = 0;
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= OP_ADD;
		req_ch.a_num    <= '0;
		req_ch.a_den    <= '0;
		req_ch.b_num    <= '0;
		req_ch.b_den    <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		for (int i = 0; i < N_DIRECTED; i++) begin
			rq = '{code: directed_rows[i].code, an: directed_rows[i].an,
				ad: directed_rows[i].ad, bn: directed_rows[i].bn, bd: directed_rows[i].bd};
			if (directed_rows[i].by_hand)
				want = '{num: directed_rows[i].num, den: directed_rows[i].den,
					eq: directed_rows[i].eq, err: directed_rows[i].err};
			else
				want = predict_result(rq);
			send_request(rq, want, 0);
		end

		// random part; phase change is safe mid-flight since only pacing moves
		for (int p = 0; p < N_PHASES; p++) begin
			stall_pct = recv_stall_pct[p];
			repeat (PER_PHASE) begin
				rq = draw_request();
				send_request(rq, predict_result(rq), send_idle_pct[p]);
			end
		end
		req_ch.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		// catch any stray extra beat
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
hdl/rau_pkg.sv
hdl/rau_if.sv
hdl/rational_arith_unit_core.sv
hdl/rau_checks.sv
tb/tb_rational_arith_unit_core.sv
